// ----- hdl/ray_triangle_intersect_assert.svh -----
// Assertion macros shared by the ray/triangle intersection RTL.
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`ifndef SYNTH
// Property that must hold on every clock edge outside reset.
`define RTI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ray_triangle_intersect: property violated");
// Condition that must never be true outside reset.
`define RTI_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ray_triangle_intersect: forbidden condition seen");
`else
`define RTI_ASSERT(lbl, prop)
`define RTI_NEVER(lbl, cond)
`endif
`endif

// ----- hdl/rti_pkg.sv -----
// Package with widths, types and helper functions of the ray/triangle intersection block.
package rti_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_INT_BITS  = 4;
    localparam int TAG_BITS        = 8;
    localparam int CW              = 1 + COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int VEC_BITS        = 3 * CW;
    localparam int DIST_BITS       = 24;
    localparam int DIST_INT_BITS   = DIST_BITS - COORD_FRAC_BITS;
    localparam int SPLIT_BITS      = CW + 2;

    // Arithmetic widths along the pipeline.
    localparam int DNW  = 2 * CW + 2;            // dot(N, D)
    localparam int NUMW = 2 * CW + 3;            // dot(N, A - O)
    localparam int RW   = DNW + DIST_BITS;       // divider remainder
    localparam int PTW  = CW + DIST_BITS + 1;    // D * t
    localparam int CRW  = 2 * CW + 3;            // cross product component
    localparam int CHW  = CRW - SPLIT_BITS;      // upper limb of a cross component
    localparam int PHW  = CHW + CW;
    localparam int PLW  = SPLIT_BITS + 1 + CW;
    localparam int SHW  = PHW + 2;
    localparam int SLW  = PLW + 2;
    localparam int TOTW = SHW + SPLIT_BITS + 1;

    // Stream and register geometry.
    localparam int IN_BITS   = 6 * VEC_BITS + TAG_BITS;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 1 + DIST_BITS + 2 * VEC_BITS + TAG_BITS + 1;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
    localparam int ADDR_BITS = 3;

    localparam logic [31:0]          EPS_RESET = 32'd42950;
    localparam logic [DIST_BITS-1:0] MIN_RESET = DIST_BITS'(33);

    // Register indexes, decoded from the word address.
    localparam logic REG_EPSILON  = 1'b0;
    localparam logic REG_MIN_DIST = 1'b1;

    // Pipeline stage numbers.
    localparam int ST_IN   = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_SIGN = 3;
    localparam int ST_OVF  = 4;
    localparam int ST_DIV0 = 5;
    localparam int ST_TMUL = ST_DIV0 + DIST_BITS;
    localparam int ST_PT   = ST_TMUL + 1;
    localparam int ST_W    = ST_PT + 1;
    localparam int ST_CR   = ST_W + 1;
    localparam int ST_SPL  = ST_CR + 1;
    localparam int ST_ACC  = ST_SPL + 1;
    localparam int ST_EDGE = ST_ACC + 1;
    localparam int NST     = ST_EDGE + 1;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [CW:0]   cdiff_t;

    // Context that travels down the pipeline; unused fields drop out in synthesis.
    typedef struct {
        coord_t                  s [3];
        coord_t                  d [3];
        coord_t                  n [3];
        coord_t                  fn [3];
        coord_t                  v [3][3];
        logic [TAG_BITS-1:0]     tag;
        cdiff_t                  diff [3];
        cdiff_t                  u [3][3];
        logic signed [2*CW-1:0]  pd [3];
        logic signed [2*CW:0]    pn [3];
        logic signed [DNW-1:0]   dn;
        logic signed [NUMW-1:0]  num;
        logic [DNW-1:0]          den;
        logic                    miss;
        logic                    ovf;
        logic [RW-1:0]           rem;
        logic [DIST_BITS-1:0]    t;
        logic signed [PTW-1:0]   pt [3];
        coord_t                  p [3];
        cdiff_t                  w [3][3];
        logic signed [CRW-1:0]   cr [3][3];
        logic signed [PHW-1:0]   ph [3][3];
        logic signed [PLW-1:0]   pl [3][3];
        logic signed [SHW-1:0]   shi [3];
        logic signed [SLW-1:0]   slo [3];
        logic                    outside;
    } ctx_t;

    // One result request, hit in the lowest bit.
    typedef struct packed {
        logic                    range_overflow;
        logic [TAG_BITS-1:0]     hit_material;
        logic [VEC_BITS-1:0]     hit_normal;
        logic [VEC_BITS-1:0]     hit_point;
        logic [DIST_BITS-1:0]    distance;
        logic                    hit;
    } res_t;

    function automatic coord_t coord_of(input logic [VEC_BITS-1:0] f, input int i);
        return f[i*CW +: CW];
    endfunction

    // Negation that saturates the most negative value.
    function automatic coord_t sat_neg(input coord_t x);
        coord_t r;
        if (x == {1'b1, {(CW-1){1'b0}}})
        begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            r = -x;
        end
        return r;
    endfunction

endpackage

// ----- hdl/ray_triangle_intersect.sv -----
// Top level of the pipelined ray/triangle intersection block.
//
//  channel   direction  handshake          contents
//  s_*       in         s_tvalid/s_tready  ray, triangle, normal, material tag
//  m_*       out        m_tvalid/m_tready  hit, distance, point, normal, tag, overflow
//  APB       in/out     psel/penable       parallel_epsilon (0x0), min_distance (0x4)
//
// One request enters per cycle while the output register is empty or taken.
// The depth is set by the 24-stage restoring divider, one quotient bit per stage.
// All stages advance together whenever the output register is empty or taken,
// so a stall holds every stage in place and nothing is lost or repeated.
// Reset clears the valid bits and loads the register defaults.
`include "ray_triangle_intersect_assert.svh"

module ray_triangle_intersect
    import rti_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // ray_origin, ray_dir, vertex_a, vertex_b, vertex_c, face_normal, material_tag
    input  logic [IN_W-1:0]      s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // hit, distance, hit_point, hit_normal, hit_material, range_overflow
    output logic [OUT_W-1:0]     m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [31:0]          eps_reg;
    logic [DIST_BITS-1:0] min_reg;
    logic                 adv;
    logic [NST-1:0]       valid_reg;
    ctx_t                 pipe_reg  [NST];
    ctx_t                 pipe_next [NST];
    logic                 m_valid_reg;
    res_t                 res_reg;
    res_t                 res_next;

    // Configuration registers.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_DIST) ? 32'(min_reg) : eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
            min_reg <= MIN_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_EPSILON)
            begin
                eps_reg <= pwdata;
            end
            else
            begin
                min_reg <= pwdata[DIST_BITS-1:0];
            end
        end
    end

    // The whole pipeline moves when the output register can take a request.
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // Decode the request and form vertex differences and edge vectors.
    always_comb
    begin
        pipe_next[ST_IN] = '{default: '0};
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_IN].s[i]    = coord_of(s_tdata[0*VEC_BITS +: VEC_BITS], i);
            pipe_next[ST_IN].d[i]    = coord_of(s_tdata[1*VEC_BITS +: VEC_BITS], i);
            pipe_next[ST_IN].v[0][i] = coord_of(s_tdata[2*VEC_BITS +: VEC_BITS], i);
            pipe_next[ST_IN].v[1][i] = coord_of(s_tdata[3*VEC_BITS +: VEC_BITS], i);
            pipe_next[ST_IN].v[2][i] = coord_of(s_tdata[4*VEC_BITS +: VEC_BITS], i);
            pipe_next[ST_IN].n[i]    = coord_of(s_tdata[5*VEC_BITS +: VEC_BITS], i);
        end
        pipe_next[ST_IN].tag = s_tdata[6*VEC_BITS +: TAG_BITS];
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_IN].diff[i] = (CW+1)'(pipe_next[ST_IN].v[0][i])
                                     - (CW+1)'(pipe_next[ST_IN].s[i]);
            pipe_next[ST_IN].u[0][i] = (CW+1)'(pipe_next[ST_IN].v[1][i])
                                     - (CW+1)'(pipe_next[ST_IN].v[0][i]);
            pipe_next[ST_IN].u[1][i] = (CW+1)'(pipe_next[ST_IN].v[2][i])
                                     - (CW+1)'(pipe_next[ST_IN].v[1][i]);
            pipe_next[ST_IN].u[2][i] = (CW+1)'(pipe_next[ST_IN].v[0][i])
                                     - (CW+1)'(pipe_next[ST_IN].v[2][i]);
        end
    end

    // Products for dot(N, D) and dot(N, A - O).
    always_comb
    begin
        pipe_next[ST_MUL] = pipe_reg[ST_MUL-1];
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_MUL].pd[i] = (2*CW)'(pipe_reg[ST_MUL-1].n[i])
                                    * (2*CW)'(pipe_reg[ST_MUL-1].d[i]);
            pipe_next[ST_MUL].pn[i] = (2*CW+1)'(pipe_reg[ST_MUL-1].n[i])
                                    * (2*CW+1)'(pipe_reg[ST_MUL-1].diff[i]);
        end
    end

    // Sum the products.
    always_comb
    begin
        pipe_next[ST_SUM] = pipe_reg[ST_SUM-1];
        pipe_next[ST_SUM].dn = DNW'(pipe_reg[ST_SUM-1].pd[0]) + DNW'(pipe_reg[ST_SUM-1].pd[1])
                             + DNW'(pipe_reg[ST_SUM-1].pd[2]);
        pipe_next[ST_SUM].num = NUMW'(pipe_reg[ST_SUM-1].pn[0])
                              + NUMW'(pipe_reg[ST_SUM-1].pn[1])
                              + NUMW'(pipe_reg[ST_SUM-1].pn[2]);
    end

    // Flip the normal, make the denominator positive and mark a parallel ray or a negative quotient as a miss.
    logic [DNW-1:0]         sign_mag;
    logic signed [NUMW-1:0] sign_num;

    always_comb
    begin
        pipe_next[ST_SIGN] = pipe_reg[ST_SIGN-1];
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_SIGN].fn[i] = (pipe_reg[ST_SIGN-1].dn > 0)
                                     ? sat_neg(pipe_reg[ST_SIGN-1].n[i])
                                     : pipe_reg[ST_SIGN-1].n[i];
        end
        if (pipe_reg[ST_SIGN-1].dn < 0)
        begin
            sign_mag = DNW'(-pipe_reg[ST_SIGN-1].dn);
            sign_num = -pipe_reg[ST_SIGN-1].num;
        end
        else
        begin
            sign_mag = DNW'(pipe_reg[ST_SIGN-1].dn);
            sign_num = pipe_reg[ST_SIGN-1].num;
        end
        pipe_next[ST_SIGN].den  = sign_mag;
        pipe_next[ST_SIGN].num  = sign_num;
        pipe_next[ST_SIGN].ovf  = 1'b0;
        pipe_next[ST_SIGN].miss = (sign_mag == '0) || (sign_mag < DNW'(eps_reg))
                                || (sign_num < 0);
    end

    // Range check of the integer part, then load the divider.
    logic [RW-1:0] ovf_lhs;
    logic [RW-1:0] ovf_rhs;

    always_comb
    begin
        pipe_next[ST_OVF] = pipe_reg[ST_OVF-1];
        ovf_lhs = RW'(unsigned'(pipe_reg[ST_OVF-1].num));
        ovf_rhs = RW'(pipe_reg[ST_OVF-1].den) << DIST_INT_BITS;
        pipe_next[ST_OVF].rem = ovf_lhs << COORD_FRAC_BITS;
        pipe_next[ST_OVF].t   = '0;
        if (!pipe_reg[ST_OVF-1].miss && (ovf_lhs >= ovf_rhs))
        begin
            pipe_next[ST_OVF].ovf  = 1'b1;
            pipe_next[ST_OVF].miss = 1'b1;
        end
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar g = 0; g < DIST_BITS; g++)
    begin : g_div
        localparam int K = ST_DIV0 + g;
        logic [RW-1:0] dsh;
        logic [RW-1:0] rest;
        logic          ge;

        always_comb
        begin
            pipe_next[K] = pipe_reg[K-1];
            dsh  = RW'(pipe_reg[K-1].den) << (DIST_BITS - 1);
            ge   = pipe_reg[K-1].rem >= dsh;
            rest = ge ? (pipe_reg[K-1].rem - dsh) : pipe_reg[K-1].rem;
            pipe_next[K].rem = rest << 1;
            pipe_next[K].t   = {pipe_reg[K-1].t[DIST_BITS-2:0], ge};
        end
    end

    // Minimum distance check and direction times distance.
    always_comb
    begin
        pipe_next[ST_TMUL] = pipe_reg[ST_TMUL-1];
        if (pipe_reg[ST_TMUL-1].t < min_reg)
        begin
            pipe_next[ST_TMUL].miss = 1'b1;
        end
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_TMUL].pt[i] = PTW'(pipe_reg[ST_TMUL-1].d[i])
                                     * PTW'($signed({1'b0, pipe_reg[ST_TMUL-1].t}));
        end
    end

    // Hit point and its range check.
    logic signed [PTW-1:0] pt_sum [3];

    always_comb
    begin
        pipe_next[ST_PT] = pipe_reg[ST_PT-1];
        for (int i = 0; i < 3; i++)
        begin
            pt_sum[i] = PTW'(pipe_reg[ST_PT-1].s[i])
                      + (pipe_reg[ST_PT-1].pt[i] >>> COORD_FRAC_BITS);
            pipe_next[ST_PT].p[i] = pt_sum[i][CW-1:0];
            if (pt_sum[i] != PTW'($signed(pt_sum[i][CW-1:0])))
            begin
                pipe_next[ST_PT].miss = 1'b1;
            end
        end
    end

    // Vectors from each edge start to the hit point.
    always_comb
    begin
        pipe_next[ST_W] = pipe_reg[ST_W-1];
        for (int e = 0; e < 3; e++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pipe_next[ST_W].w[e][i] = (CW+1)'(pipe_reg[ST_W-1].p[i])
                                        - (CW+1)'(pipe_reg[ST_W-1].v[e][i]);
            end
        end
    end

    // Cross products of edge and hit vectors.
    always_comb
    begin
        pipe_next[ST_CR] = pipe_reg[ST_CR-1];
        for (int e = 0; e < 3; e++)
        begin
            pipe_next[ST_CR].cr[e][0] =
                CRW'(pipe_reg[ST_CR-1].u[e][1]) * CRW'(pipe_reg[ST_CR-1].w[e][2])
              - CRW'(pipe_reg[ST_CR-1].u[e][2]) * CRW'(pipe_reg[ST_CR-1].w[e][1]);
            pipe_next[ST_CR].cr[e][1] =
                CRW'(pipe_reg[ST_CR-1].u[e][2]) * CRW'(pipe_reg[ST_CR-1].w[e][0])
              - CRW'(pipe_reg[ST_CR-1].u[e][0]) * CRW'(pipe_reg[ST_CR-1].w[e][2]);
            pipe_next[ST_CR].cr[e][2] =
                CRW'(pipe_reg[ST_CR-1].u[e][0]) * CRW'(pipe_reg[ST_CR-1].w[e][1])
              - CRW'(pipe_reg[ST_CR-1].u[e][1]) * CRW'(pipe_reg[ST_CR-1].w[e][0]);
        end
    end

    // Split each cross component in two limbs and weight by the normal.
    logic signed [CRW-1:0] cr_hi [3][3];

    always_comb
    begin
        pipe_next[ST_SPL] = pipe_reg[ST_SPL-1];
        for (int e = 0; e < 3; e++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cr_hi[e][i] = pipe_reg[ST_SPL-1].cr[e][i] >>> SPLIT_BITS;
                pipe_next[ST_SPL].ph[e][i] = PHW'($signed(cr_hi[e][i][CHW-1:0]))
                                           * PHW'(pipe_reg[ST_SPL-1].n[i]);
                pipe_next[ST_SPL].pl[e][i] =
                    PLW'($signed({1'b0, pipe_reg[ST_SPL-1].cr[e][i][SPLIT_BITS-1:0]}))
                  * PLW'(pipe_reg[ST_SPL-1].n[i]);
            end
        end
    end

    // Sum the limbs of each edge.
    always_comb
    begin
        pipe_next[ST_ACC] = pipe_reg[ST_ACC-1];
        for (int e = 0; e < 3; e++)
        begin
            pipe_next[ST_ACC].shi[e] = SHW'(pipe_reg[ST_ACC-1].ph[e][0])
                                     + SHW'(pipe_reg[ST_ACC-1].ph[e][1])
                                     + SHW'(pipe_reg[ST_ACC-1].ph[e][2]);
            pipe_next[ST_ACC].slo[e] = SLW'(pipe_reg[ST_ACC-1].pl[e][0])
                                     + SLW'(pipe_reg[ST_ACC-1].pl[e][1])
                                     + SLW'(pipe_reg[ST_ACC-1].pl[e][2]);
        end
    end

    // Join the limbs; a negative sum puts the point outside that edge.
    logic signed [TOTW-1:0] edge_tot [3];

    always_comb
    begin
        pipe_next[ST_EDGE] = pipe_reg[ST_EDGE-1];
        pipe_next[ST_EDGE].outside = 1'b0;
        for (int e = 0; e < 3; e++)
        begin
            edge_tot[e] = (TOTW'(pipe_reg[ST_EDGE-1].shi[e]) <<< SPLIT_BITS)
                        + TOTW'(pipe_reg[ST_EDGE-1].slo[e]);
            if (edge_tot[e] < 0)
            begin
                pipe_next[ST_EDGE].outside = 1'b1;
            end
        end
    end

    // Form the result request.
    always_comb
    begin
        res_next                = '0;
        res_next.hit            = !pipe_reg[NST-1].miss && !pipe_reg[NST-1].outside;
        res_next.range_overflow = pipe_reg[NST-1].ovf;
        if (res_next.hit)
        begin
            res_next.distance     = pipe_reg[NST-1].t;
            res_next.hit_point    = {pipe_reg[NST-1].p[2], pipe_reg[NST-1].p[1],
                                     pipe_reg[NST-1].p[0]};
            res_next.hit_normal   = {pipe_reg[NST-1].fn[2], pipe_reg[NST-1].fn[1],
                                     pipe_reg[NST-1].fn[0]};
            res_next.hit_material = pipe_reg[NST-1].tag;
        end
    end

    // Valid bits travel with the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg   <= {valid_reg[NST-2:0], s_tvalid};
            m_valid_reg <= valid_reg[NST-1];
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg <= pipe_next;
            res_reg  <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(res_reg);

    `RTI_NEVER(a_hit_with_overflow, m_valid_reg && res_reg.hit && res_reg.range_overflow)
    `RTI_ASSERT(a_miss_is_zero, m_valid_reg && !res_reg.hit |-> res_reg.distance == '0 && res_reg.hit_point == '0 && res_reg.hit_material == '0)
    `RTI_ASSERT(a_hit_beyond_min, m_valid_reg && res_reg.hit |-> res_reg.distance >= min_reg)

endmodule
